@@ rtl/core/qoi_enc_pkg.sv @@
// shared types, opcodes and the color hash for the qoi pixel encoder
// no dependencies; imported by the encoder and the checker
package qoi_enc_pkg;

  localparam int PIX_W     = 32;
  localparam int IDX_DEPTH = 64;
  localparam int IDX_AW    = $clog2(IDX_DEPTH);
  localparam int SEQ_LEN   = 14;
  localparam int SEQ_CW    = $clog2(SEQ_LEN + 1);
  localparam int OP_LEN    = 5;
  localparam int OP_CW     = $clog2(OP_LEN + 1);
  localparam int CH_W      = 3;
  localparam int ZERO_PAD  = 7;

  localparam logic [CH_W-1:0] CH_NO_ALPHA = 3'd3;
  localparam logic [CH_W-1:0] CH_RESET    = 3'd4;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;
  localparam logic [7:0] END_BYTE = 8'h01;

  localparam logic [5:0] RUN_LIMIT = 6'd62;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_stream;
  } byte_out_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgba_t;

  localparam rgba_t PIX_RESET = '{a: 8'hff, b: 8'h00, g: 8'h00, r: 8'h00};

  // r*3 + g*5 + b*7 + a*11 modulo 64, only the low six bits matter
  function automatic logic [IDX_AW-1:0] color_hash(input rgba_t p);
    logic [IDX_AW-1:0] r6, g6, b6, a6;
    r6 = p.r[IDX_AW-1:0];
    g6 = p.g[IDX_AW-1:0];
    b6 = p.b[IDX_AW-1:0];
    a6 = p.a[IDX_AW-1:0];
    return r6 * IDX_AW'(3) + g6 * IDX_AW'(5) + b6 * IDX_AW'(7) + a6 * IDX_AW'(11);
  endfunction

endpackage

@@ rtl/core/qoi_image_encoder.sv @@
// qoi encoder: first output byte valid once a pixel passes stage 1 registers into the
// output shift register; one pixel per cycle while each pixel yields at most one byte
// and the output is not stalled, a pixel with more bytes holds the single byte output
// lane, and so the input, until its last byte is out; reset is synchronous, active low;
// index valid bits clear at once; a last pixel returns previous pixel, run count and
// index to their reset values; depends on qoi_enc_pkg and qoi_enc_ram
module qoi_image_encoder
  import qoi_enc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  // pixel input channel
  input  logic            in_valid,
  output logic            in_stall,
  input  pix_in_t         in_data,
  // encoded byte channel
  output logic            out_valid,
  input  logic            out_stall,
  output byte_out_t       out_data,
  // channel count register
  input  logic            cfg_we,
  input  logic [CH_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= CH_RESET;
    end else if (cfg_we) begin
      chan_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: pixel accept, alpha substitution, hash and index read
  // ---------------------------------------------------------------------------
  logic              in_acc;
  rgba_t             in_px;
  logic [IDX_AW-1:0] in_slot;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    in_px.r = in_data.red;
    in_px.g = in_data.green;
    in_px.b = in_data.blue;
    // with three channels alpha is pinned to opaque
    in_px.a = (chan_r == CH_NO_ALPHA) ? 8'hff : in_data.alpha;
  end

  assign in_slot = color_hash(in_px);

  // ---------------------------------------------------------------------------
  // stage 1 registers
  // ---------------------------------------------------------------------------
  logic              s1_v_r;
  rgba_t             s1_px_r;
  logic [IDX_AW-1:0] s1_slot_r;
  logic              s1_last_r;

  // forwarding of the index write that lands on the same edge as our read
  logic              fwd_hit_r;
  rgba_t             fwd_px_r;

  // encoder state held next to the index memory
  rgba_t             prev_r;
  logic [5:0]        run_r;
  logic [IDX_DEPTH-1:0] vld_r;

  logic [PIX_W-1:0]  ram_q;
  logic              s1_adv;
  logic              idx_wr;

  qoi_enc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (IDX_DEPTH)
  ) u_idx_ram (
    .clk   (clk),
    .we    (idx_wr),
    .waddr (s1_slot_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (in_slot),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r    <= 1'b1;
        // the stage 1 pixel writes this slot at this very edge
        fwd_hit_r <= idx_wr && (s1_slot_r == in_slot);
      end else if (s1_adv) begin
        s1_v_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_px;
      s1_slot_r <= in_slot;
      s1_last_r <= in_data.last_pixel;
      fwd_px_r  <= s1_px_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: classify the pixel and build its byte sequence
  // ---------------------------------------------------------------------------
  rgba_t      idx_word;
  logic       same_px;
  logic       idx_hit;
  logic [5:0] run_inc;
  logic       run_full;
  logic [7:0] vr, vg, vb, vgr, vgb;
  logic [7:0] dr2, dg2, db2, lg, lr, lb;
  logic       is_diff, is_luma;

  logic       pre_v;
  logic [7:0] pre_byte;
  logic [7:0] op_b [OP_LEN];
  logic [OP_CW-1:0] op_cnt;
  logic       trun_v;
  logic [7:0] trun_byte;
  logic [SEQ_CW-1:0] seq_cnt;
  logic [7:0] seq [SEQ_LEN];

  // an entry never written reads as all zeros
  assign idx_word = !vld_r[s1_slot_r] ? rgba_t'('0) :
                    fwd_hit_r ? fwd_px_r : rgba_t'(ram_q);
  assign same_px  = (s1_px_r == prev_r);
  assign idx_hit  = (idx_word == s1_px_r);
  assign run_inc  = run_r + 6'd1;
  assign run_full = (run_inc == RUN_LIMIT);

  // channel deltas wrap to eight bits
  assign vr  = s1_px_r.r - prev_r.r;
  assign vg  = s1_px_r.g - prev_r.g;
  assign vb  = s1_px_r.b - prev_r.b;
  assign vgr = vr - vg;
  assign vgb = vb - vg;

  // biased deltas, range checks become unsigned compares
  assign dr2 = vr + 8'd2;
  assign dg2 = vg + 8'd2;
  assign db2 = vb + 8'd2;
  assign lg  = vg + 8'd32;
  assign lr  = vgr + 8'd8;
  assign lb  = vgb + 8'd8;

  assign is_diff = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
  assign is_luma = (lg < 8'd64) && (lr < 8'd16) && (lb < 8'd16);

  assign idx_wr = s1_adv && !same_px && !idx_hit;

  always_comb begin
    for (int j = 0; j < OP_LEN; j++) begin
      op_b[j] = 8'h00;
    end
    op_cnt = '0;
    if (!same_px) begin
      priority if (idx_hit) begin
        op_b[0] = OP_INDEX | {2'b00, s1_slot_r};
        op_cnt  = OP_CW'(1);
      end else if (prev_r.a != s1_px_r.a) begin
        op_b[0] = OP_RGBA;
        op_b[1] = s1_px_r.r;
        op_b[2] = s1_px_r.g;
        op_b[3] = s1_px_r.b;
        op_b[4] = s1_px_r.a;
        op_cnt  = OP_CW'(5);
      end else if (is_diff) begin
        op_b[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
        op_cnt  = OP_CW'(1);
      end else if (is_luma) begin
        op_b[0] = OP_LUMA | {2'b00, lg[5:0]};
        op_b[1] = {lr[3:0], lb[3:0]};
        op_cnt  = OP_CW'(2);
      end else begin
        op_b[0] = OP_RGB;
        op_b[1] = s1_px_r.r;
        op_b[2] = s1_px_r.g;
        op_b[3] = s1_px_r.b;
        op_cnt  = OP_CW'(4);
      end
    end
  end

  // run byte ahead of the op: a full run, or a pending run broken by a new color
  always_comb begin
    pre_v    = 1'b0;
    pre_byte = OP_RUN | {2'b00, run_r - 6'd1};
    if (same_px) begin
      pre_v    = run_full;
      pre_byte = OP_RUN | {2'b00, run_r};
    end else if (run_r != 6'd0) begin
      pre_v    = 1'b1;
    end
  end

  // pending run flushed in front of the end marker
  assign trun_v    = s1_last_r && same_px && !run_full;
  assign trun_byte = OP_RUN | {2'b00, run_r};

  assign seq_cnt = SEQ_CW'(pre_v) + SEQ_CW'(op_cnt) +
                   (s1_last_r ? SEQ_CW'(ZERO_PAD + 1) + SEQ_CW'(trun_v) : SEQ_CW'(0));

  // lay run prefix, op bytes, trailing run byte, zero padding and end marker out in one flat byte row
  always_comb begin : compose_seq
    logic [SEQ_CW-1:0] rel;
    logic [SEQ_CW-1:0] rel2;
    logic [SEQ_CW-1:0] pad;
    for (int k = 0; k < SEQ_LEN; k++) begin
      rel  = SEQ_CW'(k) - SEQ_CW'(pre_v);
      rel2 = rel - SEQ_CW'(op_cnt);
      pad  = rel2 - SEQ_CW'(trun_v);
      if (pre_v && (k == 0)) begin
        seq[k] = pre_byte;
      end else if (rel < SEQ_CW'(op_cnt)) begin
        seq[k] = op_b[rel[OP_CW-1:0]];
      end else if (trun_v && (rel2 == '0)) begin
        seq[k] = trun_byte;
      end else if (pad == SEQ_CW'(ZERO_PAD)) begin
        seq[k] = END_BYTE;
      end else begin
        seq[k] = 8'h00;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output shift register, one byte per transaction
  // ---------------------------------------------------------------------------
  logic [7:0]        ser_r [SEQ_LEN];
  logic [SEQ_CW-1:0] ser_cnt_r;
  logic              ser_last_r;
  logic              out_pop;
  logic              ser_free;
  logic              s1_emits;

  assign out_valid = (ser_cnt_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign ser_free  = (ser_cnt_r == '0) || ((ser_cnt_r == SEQ_CW'(1)) && !out_stall);
  assign s1_emits  = (seq_cnt != '0);

  // a silent pixel moves on regardless of the output side
  assign s1_adv   = s1_v_r && (!s1_emits || ser_free);
  assign in_stall = s1_v_r && !s1_adv;

  assign out_data.out_byte      = ser_r[0];
  assign out_data.last_of_item  = (ser_cnt_r == SEQ_CW'(1));
  assign out_data.end_of_stream = ser_last_r && (ser_cnt_r == SEQ_CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_cnt_r <= '0;
    end else if (s1_adv && s1_emits) begin
      ser_cnt_r <= seq_cnt;
    end else if (out_pop) begin
      ser_cnt_r <= ser_cnt_r - SEQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emits) begin
      ser_r      <= seq;
      ser_last_r <= s1_last_r;
    end else if (out_pop) begin
      for (int k = 0; k < SEQ_LEN - 1; k++) begin
        ser_r[k] <= ser_r[k + 1];
      end
      ser_r[SEQ_LEN - 1] <= 8'h00;
    end
  end

  // ---------------------------------------------------------------------------
  // encoder state update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= PIX_RESET;
      run_r  <= '0;
      vld_r  <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        // end of image: back to the reset state, index reads as zeros again
        prev_r <= PIX_RESET;
        run_r  <= '0;
        vld_r  <= '0;
      end else begin
        prev_r <= s1_px_r;
        run_r  <= (same_px && !run_full) ? run_inc : 6'd0;
        if (idx_wr) begin
          vld_r[s1_slot_r] <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/qoi_enc_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module qoi_enc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/qoi_enc_checker.sv @@
// port level checks for the qoi encoder, bound to the top level
// depends on qoi_enc_pkg and qoi_image_encoder
module qoi_enc_checker
  import qoi_enc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input byte_out_t out_data
);

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // end of stream is the closing 0x01 and ends its pixel's bytes
  a_eos_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_stream |->
      out_data.last_of_item && (out_data.out_byte == END_BYTE))
    else $error("end of stream on a wrong byte");

  // the end byte directly follows a zero pad byte
  a_eos_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_stream && $past(rst_n) && $past(out_valid && !out_stall)
      |-> ($past(out_data.out_byte) == 8'h00))
    else $error("end byte not preceded by padding");

  // bytes of one pixel go out without gaps
  a_item_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_item |=> out_valid)
    else $error("gap inside a pixel's bytes");

endmodule

bind qoi_image_encoder qoi_enc_checker u_qoi_enc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
